>>> rtl/core/slu_pkg.sv
// ----------------------------------------------------------------------------
// slu_pkg
// shared types, codes and character helpers for the string literal unescape
// core
// ----------------------------------------------------------------------------
package slu_pkg;

  // result event codes
  typedef enum logic [2:0] {
    EV_DATA   = 3'd0,
    EV_CLOSED = 3'd1,
    EV_NUL    = 3'd2,
    EV_NOOPEN = 3'd3,
    EV_UNTERM = 3'd4
  } ev_t;

  // decoder modes
  typedef enum logic [2:0] {
    M_IDLE = 3'd0,
    M_BODY = 3'd1,
    M_ESC  = 3'd2,
    M_HEX0 = 3'd3,
    M_HEX1 = 3'd4,
    M_HEX2 = 3'd5,
    M_OCT1 = 3'd6,
    M_OCT2 = 3'd7
  } mode_t;

  // configuration register indexes
  localparam logic CfgDelimiter = 1'b0;
  localparam logic CfgCheckEnd  = 1'b1;

  localparam logic [7:0] DelimiterReset = 8'h22;
  localparam logic       CheckEndReset  = 1'b1;

  // queue between front and back
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  // characters
  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChBslash = 8'h5c;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChSeven = 8'h37;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpF   = 8'h46;
  localparam logic [7:0] ChLoA   = 8'h61;
  localparam logic [7:0] ChLoB   = 8'h62;
  localparam logic [7:0] ChLoF   = 8'h66;
  localparam logic [7:0] ChLoN   = 8'h6e;
  localparam logic [7:0] ChLoR   = 8'h72;
  localparam logic [7:0] ChLoT   = 8'h74;
  localparam logic [7:0] ChLoV   = 8'h76;
  localparam logic [7:0] ChLoX   = 8'h78;

  // one queue word: one or two results of a single input byte
  typedef struct packed {
    logic       two;
    ev_t        ev0;
    logic [7:0] d0;
    ev_t        ev1;
    logic [7:0] d1;
  } entry_t;

  // {valid, digit value}
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [7:0] t;
    logic [4:0] r;
    r = '0;
    t = '0;
    if (b >= ChZero && b <= ChNine) begin
      r = {1'b1, b[3:0]};
    end else if (b >= ChLoA && b <= ChLoF) begin
      t = b - 8'h57;
      r = {1'b1, t[3:0]};
    end else if (b >= ChUpA && b <= ChUpF) begin
      t = b - 8'h37;
      r = {1'b1, t[3:0]};
    end
    return r;
  endfunction

  function automatic logic is_oct(input logic [7:0] b);
    return (b >= ChZero) && (b <= ChSeven);
  endfunction

endpackage

>>> rtl/core/slu_front.sv
// ----------------------------------------------------------------------------
// slu_front
// takes source bytes, runs the literal/escape state and builds queue words
// ----------------------------------------------------------------------------
module slu_front import slu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] delimiter,
  input  logic       check_end,
  input  logic       accept,
  input  logic [7:0] in_byte,
  output logic       push,
  output entry_t     entry
);

  mode_t      mode, mode_next;
  logic [7:0] escape_value, escape_value_next;

  // plain body byte handling
  logic       body_has;
  ev_t        body_ev;
  logic [7:0] body_data;
  mode_t      body_mode;

  logic [4:0] hx;
  logic       flush;
  logic       has0;
  ev_t        ev0;
  logic [7:0] d0;

  always_comb begin
    body_has  = 1'b1;
    body_ev   = EV_DATA;
    body_data = 8'h00;
    body_mode = M_IDLE;
    if (in_byte == delimiter) begin
      body_ev = EV_CLOSED;
    end else if (in_byte == ChBslash) begin
      body_has  = 1'b0;
      body_mode = M_ESC;
    end else if (in_byte < ChSpace && check_end) begin
      body_ev = EV_UNTERM;
    end else if (in_byte == ChNul) begin
      body_ev = EV_NUL;
    end else begin
      body_data = in_byte;
      body_mode = M_BODY;
    end
  end

  always_comb begin
    hx                = hex_digit(in_byte);
    mode_next         = mode;
    escape_value_next = escape_value;
    flush             = 1'b0;
    has0              = 1'b0;
    ev0               = EV_DATA;
    d0                = 8'h00;
    unique case (mode)
      M_IDLE: begin
        if (in_byte == delimiter) begin
          mode_next = M_BODY;
        end else begin
          has0 = 1'b1;
          ev0  = EV_NOOPEN;
        end
      end
      M_BODY: begin
        has0      = body_has;
        ev0       = body_ev;
        d0        = body_data;
        mode_next = body_mode;
      end
      M_ESC: begin
        mode_next = M_BODY;
        has0      = 1'b1;
        unique case (in_byte)
          ChLoA: d0 = 8'h07;
          ChLoB: d0 = 8'h08;
          ChLoT: d0 = 8'h09;
          ChLoV: d0 = 8'h0b;
          ChLoN: d0 = 8'h0a;
          ChLoR: d0 = 8'h0d;
          ChLoF: d0 = 8'h0c;
          ChLoX: begin
            has0              = 1'b0;
            escape_value_next = 8'h00;
            mode_next         = M_HEX0;
          end
          ChNul: begin
            ev0       = check_end ? EV_UNTERM : EV_NUL;
            mode_next = M_IDLE;
          end
          default: begin
            if (is_oct(in_byte)) begin
              has0              = 1'b0;
              escape_value_next = {5'd0, in_byte[2:0]};
              mode_next         = M_OCT1;
            end else begin
              d0 = in_byte;
            end
          end
        endcase
      end
      M_HEX0, M_HEX1: begin
        if (hx[4]) begin
          escape_value_next = {escape_value[3:0], hx[3:0]};
          mode_next         = (mode == M_HEX0) ? M_HEX1 : M_HEX2;
        end else begin
          flush = 1'b1;
        end
      end
      M_HEX2: begin
        if (hx[4]) begin
          escape_value_next = {escape_value[3:0], hx[3:0]};
          has0              = 1'b1;
          d0                = {escape_value[3:0], hx[3:0]};
          mode_next         = M_BODY;
        end else begin
          flush = 1'b1;
        end
      end
      M_OCT1: begin
        if (is_oct(in_byte)) begin
          escape_value_next = {escape_value[4:0], in_byte[2:0]};
          mode_next         = M_OCT2;
        end else begin
          flush = 1'b1;
        end
      end
      M_OCT2: begin
        if (is_oct(in_byte)) begin
          escape_value_next = {escape_value[4:0], in_byte[2:0]};
          has0              = 1'b1;
          d0                = {escape_value[4:0], in_byte[2:0]};
          mode_next         = M_BODY;
        end else begin
          flush = 1'b1;
        end
      end
      default: ;
    endcase

    // numeric escape ends: emit its value, then handle the byte as body
    if (flush) begin
      has0      = 1'b1;
      ev0       = EV_DATA;
      d0        = escape_value;
      mode_next = body_mode;
    end
  end

  always_comb begin
    push      = accept && has0;
    entry.two = flush && body_has;
    entry.ev0 = ev0;
    entry.d0  = d0;
    entry.ev1 = body_ev;
    entry.d1  = body_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= M_IDLE;
      escape_value <= 8'h00;
    end else if (accept) begin
      mode         <= mode_next;
      escape_value <= escape_value_next;
    end
  end

endmodule

>>> rtl/core/slu_queue.sv
// ----------------------------------------------------------------------------
// slu_queue
// short fifo of result words between the front and the back
// ----------------------------------------------------------------------------
module slu_queue import slu_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  input  logic   pop,
  output logic   full,
  output logic   head_valid,
  output entry_t head
);

  entry_t           mem [QDepth];
  logic [QPtrW-1:0] wr_ptr, rd_ptr;
  logic [QCntW-1:0] count;

  assign full       = (count == QCntW'(QDepth));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/core/slu_back.sv
// ----------------------------------------------------------------------------
// slu_back
// holds one queue word and hands out its results one per output word
// ----------------------------------------------------------------------------
module slu_back import slu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       head_valid,
  input  entry_t     head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] event_res,
  output logic [7:0] data_byte,
  output logic       last
);

  logic   held;
  logic   idx;
  entry_t cur;
  logic   finishing;

  assign finishing = idx || !cur.two;
  assign pop       = head_valid && (!held || (out_ready && finishing));

  assign out_valid = held;
  assign event_res = idx ? cur.ev1 : cur.ev0;
  assign data_byte = idx ? cur.d1 : cur.d0;
  assign last      = finishing;

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
      idx  <= 1'b0;
    end else if (pop) begin
      held <= 1'b1;
      idx  <= 1'b0;
    end else if (held && out_ready) begin
      if (finishing) begin
        held <= 1'b0;
        idx  <= 1'b0;
      end else begin
        idx <= 1'b1;
      end
    end
  end

endmodule

>>> rtl/core/string_literal_unescape_core.sv
// ----------------------------------------------------------------------------
// string_literal_unescape_core
// streaming decoder for one quoted c-style string literal, one byte a word
// ----------------------------------------------------------------------------
// usage:
//   in channel (in_valid/in_ready/in_byte) takes one raw source byte a word
//   out channel (out_valid/out_ready) gives event_res, data_byte and last;
//     a byte gives zero, one or two result words, last marks its final one
//   cfg_we/cfg_index/cfg_data write delimiter (index 0) and check_end
//     (index 1); write only while the core is idle
// timing:
//   a byte is taken every cycle while the 4-word queue has room; the first
//   result of a byte passes the queue and the back's register to out_valid
//   one result word leaves per cycle while out_ready is high, so a byte with two
//   results holds the output until both leave; the queue absorbs that and short
//   receiver stalls; when the queue is full in_ready drops until the back pops a word
// reset:
//   synchronous rst empties the queue, drops out_valid, returns the decoder
//   to waiting for the opening delimiter, delimiter to 0x22, check_end to 1
// ----------------------------------------------------------------------------
module string_literal_unescape_core import slu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] event_res,
  output logic [7:0] data_byte,
  output logic       last,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);

  // configuration registers
  logic [7:0] delimiter;
  logic       check_end;

  // front to queue
  logic   accept;
  logic   push;
  entry_t push_entry;

  // queue to back
  logic   q_full;
  logic   q_valid;
  logic   pop;
  entry_t q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      delimiter <= DelimiterReset;
      check_end <= CheckEndReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgDelimiter: delimiter <= cfg_data;
        CfgCheckEnd:  check_end <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // front takes a word whenever the queue can hold whatever it yields
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  slu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .delimiter (delimiter),
    .check_end (check_end),
    .accept    (accept),
    .in_byte   (in_byte),
    .push      (push),
    .entry     (push_entry)
  );

  slu_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (q_full),
    .head_valid (q_valid),
    .head       (q_head)
  );

  // back serializes each queue word onto the registered output
  slu_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_valid),
    .head       (q_head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .event_res  (event_res),
    .data_byte  (data_byte),
    .last       (last)
  );

endmodule
